[design/wmd_pkg.sv]
// ----------------------------------------------------------------------------
// wmd_pkg
// Shared types and codes for the window motion detect / blend block.
// ----------------------------------------------------------------------------
package wmd_pkg;

  // pixel commands
  localparam logic [1:0] CMD_DETECT = 2'd0;
  localparam logic [1:0] CMD_COPY   = 2'd1;
  localparam logic [1:0] CMD_BLEND  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_FRAME_WIDTH    = 3'd0;
  localparam logic [2:0] CFG_WINDOW_LEFT    = 3'd1;
  localparam logic [2:0] CFG_WINDOW_TOP     = 3'd2;
  localparam logic [2:0] CFG_WINDOW_COLUMNS = 3'd3;
  localparam logic [2:0] CFG_WINDOW_ROWS    = 3'd4;
  localparam logic [2:0] CFG_DIFF_THRESHOLD = 3'd5;
  localparam logic [2:0] CFG_OPACITY        = 3'd6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int COL_W      = 12;
  localparam int ROW_W      = 11;
  localparam int CNT_W      = 13;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] live_luma;
    logic [7:0] dest_luma;
    logic       last_pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_luma;
    logic             inside_window;
    logic [CNT_W-1:0] changed_count;
    logic             frame_done;
  } out_item_t;

  typedef struct packed {
    logic [COL_W-1:0] width_eff;   // row width after clamping
    logic [10:0]      window_left;
    logic [10:0]      window_top;
    logic [11:0]      window_columns;
    logic [11:0]      window_rows;
    logic [7:0]       diff_threshold;
    logic [7:0]       opacity;
  } cfg_t;

endpackage

[design/window_motion_detect_blend.sv]
// ----------------------------------------------------------------------------
// window_motion_detect_blend
// Frame-difference motion detection and blend over a stored window.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock while the output side does not stall; each
// result is held in stage 1 while its RAM read is in flight, then registered
// in an output register, where it waits while the output side stalls. The
// rate is set by the window RAM: each pixel issues one read on the accept
// cycle and its write-back when it leaves stage 1, on a separate write port;
// when the last window pixel of one frame and the first of the next hit the
// same entry, the written value is forwarded. The window store is not cleared
// after reset, so detect and blend must follow a copy frame.
// ----------------------------------------------------------------------------
module window_motion_detect_blend
  import wmd_pkg::*;
#(
  parameter int MAX_WINDOW_PIXELS = 4096,
  parameter int MAX_FRAME_WIDTH   = 2048
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  localparam int ADDR_W = $clog2(MAX_WINDOW_PIXELS);

  cfg_t              cfg;
  logic              accept;
  logic              pos_inside;
  logic [ADDR_W-1:0] pos_addr;
  logic [7:0]        ram_rdata;

  // stage 1: RAM data in flight
  logic              s1_valid_r, s1_valid_nxt;
  in_item_t          s1_item_r;
  logic              s1_inside_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              fwd_hit_r, fwd_hit_nxt;
  logic [7:0]        fwd_data_r;
  logic              s1_adv;

  logic [CNT_W-1:0]  total_r, total_nxt, total_upd;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r;

  logic [7:0]        stored;
  logic [7:0]        diff;
  logic [15:0]       blend_sum;
  logic              wr_en;
  logic              is_changed;
  out_item_t         result;

  wmd_cfg #(.MAX_FRAME_WIDTH(MAX_FRAME_WIDTH)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wmd_raster #(.MAX_WINDOW_PIXELS(MAX_WINDOW_PIXELS)) u_raster (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .advance    (accept),
    .last_pixel (in_data.last_pixel),
    .in_window  (pos_inside),
    .addr       (pos_addr)
  );

  wmd_ram #(.WIDTH(8), .DEPTH(MAX_WINDOW_PIXELS)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (s1_item_r.live_luma),
    .rd_en   (accept),
    .rd_addr (pos_addr),
    .rd_data (ram_rdata)
  );

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    stored = fwd_hit_r ? fwd_data_r : ram_rdata;
    diff   = (s1_item_r.live_luma > stored) ? s1_item_r.live_luma - stored
                                            : stored - s1_item_r.live_luma;
    blend_sum = ({8'b0, stored} * {8'b0, cfg.opacity})
              + ({8'b0, s1_item_r.dest_luma} * {8'b0, 8'd255 - cfg.opacity});

    wr_en = s1_adv && s1_inside_r
         && (s1_item_r.command == CMD_DETECT || s1_item_r.command == CMD_COPY);

    is_changed = s1_inside_r && (s1_item_r.command == CMD_DETECT)
              && (diff > cfg.diff_threshold);
    total_upd = (is_changed && total_r != CNT_MAX) ? total_r + CNT_W'(1) : total_r;

    result.out_luma      = (s1_inside_r && s1_item_r.command == CMD_BLEND)
                         ? blend_sum[15:8] : s1_item_r.dest_luma;
    result.inside_window = s1_inside_r;
    result.changed_count = total_upd;
    result.frame_done    = s1_item_r.last_pixel;

    total_nxt = total_r;
    if (s1_adv) begin
      total_nxt = s1_item_r.last_pixel ? '0 : total_upd;
    end

    s1_valid_nxt = accept || (s1_valid_r && !s1_adv);

    // same entry written back while the next pixel reads it
    fwd_hit_nxt = fwd_hit_r;
    if (accept) begin
      fwd_hit_nxt = wr_en && (s1_addr_r == pos_addr);
    end

    out_valid_nxt = s1_adv || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_hit_r   <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      fwd_hit_r   <= fwd_hit_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r   <= in_data;
      s1_inside_r <= pos_inside;
      s1_addr_r   <= pos_addr;
      fwd_data_r  <= s1_item_r.live_luma;
    end
    if (s1_adv) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/wmd_ram.sv]
// ----------------------------------------------------------------------------
// wmd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/wmd_cfg.sv]
// ----------------------------------------------------------------------------
// wmd_cfg
// Configuration registers and derived row width.
// ----------------------------------------------------------------------------
module wmd_cfg
  import wmd_pkg::*;
#(
  parameter int MAX_FRAME_WIDTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [11:0] frame_width_r, frame_width_nxt;
  logic [10:0] left_r, left_nxt, top_r, top_nxt;
  logic [11:0] cols_r, cols_nxt, rows_r, rows_nxt;
  logic [7:0]  thr_r, thr_nxt, opa_r, opa_nxt;

  always_comb begin
    frame_width_nxt = frame_width_r;
    left_nxt        = left_r;
    top_nxt         = top_r;
    cols_nxt        = cols_r;
    rows_nxt        = rows_r;
    thr_nxt         = thr_r;
    opa_nxt         = opa_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:    frame_width_nxt = cfg_data;
        CFG_WINDOW_LEFT:    left_nxt        = cfg_data[10:0];
        CFG_WINDOW_TOP:     top_nxt         = cfg_data[10:0];
        CFG_WINDOW_COLUMNS: cols_nxt        = cfg_data;
        CFG_WINDOW_ROWS:    rows_nxt        = cfg_data;
        CFG_DIFF_THRESHOLD: thr_nxt         = cfg_data[7:0];
        CFG_OPACITY:        opa_nxt         = cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= 12'd720;
      left_r        <= '0;
      top_r         <= '0;
      cols_r        <= 12'd64;
      rows_r        <= 12'd64;
      thr_r         <= 8'd16;
      opa_r         <= 8'd128;
    end else begin
      frame_width_r <= frame_width_nxt;
      left_r        <= left_nxt;
      top_r         <= top_nxt;
      cols_r        <= cols_nxt;
      rows_r        <= rows_nxt;
      thr_r         <= thr_nxt;
      opa_r         <= opa_nxt;
    end
  end

  always_comb begin
    // zero acts as one, anything above the supported width is clamped
    if (frame_width_r == '0) begin
      cfg.width_eff = COL_W'(1);
    end else if (32'(frame_width_r) > MAX_FRAME_WIDTH) begin
      cfg.width_eff = COL_W'(MAX_FRAME_WIDTH);
    end else begin
      cfg.width_eff = frame_width_r;
    end
    cfg.window_left    = left_r;
    cfg.window_top     = top_r;
    cfg.window_columns = cols_r;
    cfg.window_rows    = rows_r;
    cfg.diff_threshold = thr_r;
    cfg.opacity        = opa_r;
  end

endmodule

[design/wmd_raster.sv]
// ----------------------------------------------------------------------------
// wmd_raster
// Column / row / store index tracking and window hit test.
// ----------------------------------------------------------------------------
module wmd_raster
  import wmd_pkg::*;
#(
  parameter int MAX_WINDOW_PIXELS = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cfg_t                                 cfg,
  input  logic                                 advance,
  input  logic                                 last_pixel,
  output logic                                 in_window,
  output logic [$clog2(MAX_WINDOW_PIXELS)-1:0] addr
);

  localparam int IDX_W = $clog2(MAX_WINDOW_PIXELS + 1);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [COL_W:0]   col_end;
  logic [ROW_W+1:0] row_end;

  always_comb begin
    col_end = {1'b0, cfg.window_left} + {1'b0, cfg.window_columns};
    row_end = {2'b0, cfg.window_top} + {1'b0, cfg.window_rows};
    in_window = (col_r >= {1'b0, cfg.window_left})
             && ({1'b0, col_r} < col_end)
             && (row_r >= cfg.window_top)
             && ({2'b0, row_r} < row_end)
             && (idx_r < IDX_W'(MAX_WINDOW_PIXELS));
    addr = idx_r[$clog2(MAX_WINDOW_PIXELS)-1:0];

    col_nxt = col_r;
    row_nxt = row_r;
    idx_nxt = idx_r;
    if (advance) begin
      if (in_window) begin
        idx_nxt = idx_r + IDX_W'(1);
      end
      if (last_pixel) begin
        col_nxt = '0;
        row_nxt = '0;
        idx_nxt = '0;
      end else if (({1'b0, col_r} + 13'd1) >= {1'b0, cfg.width_eff}) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      idx_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule

[design/wmd_checker.sv]
// ----------------------------------------------------------------------------
// wmd_checker
// Port-level checks for window_motion_detect_blend, attached by bind.
// ----------------------------------------------------------------------------
module wmd_checker
  import wmd_pkg::*;
#(
  parameter int MAX_WINDOW_PIXELS = 4096
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  // input is only held off by the output side
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output flows");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a frame cannot count more changes than it has window pixels
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.changed_count) <= MAX_WINDOW_PIXELS)
    else $error("changed count exceeds window capacity");

endmodule

bind window_motion_detect_blend wmd_checker #(
  .MAX_WINDOW_PIXELS(MAX_WINDOW_PIXELS)
) u_wmd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
